[hw/rtl/rbbt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbbt_pkg
// Shared constants, codes and control types of the ring buffer transfer core.
// ----------------------------------------------------------------------------
package rbbt_pkg;

    localparam int DEPTH_DEFAULT    = 1024;
    localparam int MAX_READ_DEFAULT = 64;

    // ring_size after reset, before clamping to the slot count
    localparam int RING_SIZE_RESET  = 1024;
    localparam int RING_SIZE_MIN    = 2;

    localparam int SIZE_CFG_W = 11;
    localparam int LEN_W      = 7;
    localparam int COUNT_W    = 10;
    localparam int STATUS_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_READ_BYTE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WRITE_DONE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WRITE_BLOCK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_BLOCK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY  = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic do_write;   // write beat accepted
        logic rd_block;   // read request on an empty buffer
        logic rd_zero;    // zero-length read on a non-empty buffer
        logic rd_start;   // read request that moves bytes
        logic rd_emit;    // load the fetched byte into the output register
        logic fetch;      // read one slot at the read index and advance it
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic len_zero;
        logic final_byte;
        logic out_free;
    } dp_status_t;

endpackage : rbbt_pkg
`default_nettype wire

[hw/rtl/rbbt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbbt_ctrl
// Sequencer: takes input beats, starts reads and paces byte emission.
// ----------------------------------------------------------------------------
module rbbt_ctrl
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    input  wire                   operation,
    input  rbbt_pkg::dp_status_t  dp_status,
    output logic                  in_ready,
    output rbbt_pkg::ctrl_cmd_t   cmd
);
    import rbbt_pkg::*;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_READ = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       accept;
    logic       is_read;

    assign in_ready = (state_reg == S_IDLE) && dp_status.out_free;
    assign accept   = in_valid && in_ready;
    assign is_read  = (operation == OP_READ);

    always_comb
    begin
        cmd.do_write = accept && !is_read;
        cmd.rd_block = accept && is_read && dp_status.empty;
        cmd.rd_zero  = accept && is_read && !dp_status.empty && dp_status.len_zero;
        cmd.rd_start = accept && is_read && !dp_status.empty && !dp_status.len_zero;
        cmd.rd_emit  = (state_reg == S_READ) && dp_status.out_free;
        // prefetch the next byte while the current one goes out
        cmd.fetch    = cmd.rd_start || (cmd.rd_emit && !dp_status.final_byte);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.rd_start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cmd.rd_emit && dp_status.final_byte)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : rbbt_ctrl
`default_nettype wire

[hw/rtl/rbbt_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbbt_datapath
// Slot memory, ring indices, burst bookkeeping, read counters and the
// output register.
// ----------------------------------------------------------------------------
module rbbt_datapath
#(
    parameter int DEPTH    = rbbt_pkg::DEPTH_DEFAULT,
    parameter int MAX_READ = rbbt_pkg::MAX_READ_DEFAULT
)
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_write,
    input  wire  [rbbt_pkg::SIZE_CFG_W-1:0]       cfg_data,
    input  wire  [7:0]                            data_byte,
    input  wire                                   first_of_burst,
    input  wire                                   last_of_burst,
    input  wire  [rbbt_pkg::LEN_W-1:0]            read_length,
    input  rbbt_pkg::ctrl_cmd_t                   cmd,
    output rbbt_pkg::dp_status_t                  dp_status,
    input  wire                                   out_ready,
    output logic                                  out_valid,
    output logic [rbbt_pkg::STATUS_W-1:0]         status,
    output logic [7:0]                            read_byte,
    output logic [rbbt_pkg::COUNT_W-1:0]          byte_count,
    output logic                                  last_result
);
    import rbbt_pkg::*;

    localparam int IW   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int SW   = $clog2(DEPTH + 1);
    localparam int CW   = (SW > SIZE_CFG_W) ? SW : SIZE_CFG_W;
    localparam int LW   = $clog2(MAX_READ + 1);
    localparam int MW   = (SW > LEN_W) ? SW : LEN_W;
    localparam int RESET_SIZE = (RING_SIZE_RESET > DEPTH) ? DEPTH : RING_SIZE_RESET;

    logic [SW-1:0]      size_reg;
    logic [IW-1:0]      wr_idx_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic [COUNT_W-1:0] burst_cnt_reg;
    logic               burst_ref_reg;
    logic [LW-1:0]      remain_reg;
    logic [LW-1:0]      rcount_reg;
    logic [7:0]         mem_q;
    logic [7:0]         slot_mem [DEPTH];

    logic               out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [7:0]         read_byte_reg;
    logic [COUNT_W-1:0] byte_count_reg;
    logic               last_reg;

    logic [CW-1:0]      cfg_ext;
    logic [SW-1:0]      size_next;
    logic [SW-1:0]      wr_inc;
    logic [SW-1:0]      rd_inc;
    logic [IW-1:0]      wr_adv;
    logic [IW-1:0]      rd_adv;
    logic [SW-1:0]      avail;
    logic               full;
    logic               refused;
    logic               store;
    logic [COUNT_W-1:0] cnt_base;
    logic [COUNT_W-1:0] cnt_new;
    logic [LEN_W-1:0]   len_clamp;
    logic [MW-1:0]      avail_ext;
    logic [MW-1:0]      len_ext;
    logic [LW-1:0]      take;
    logic               out_load;

    // clamp the requested size into [2, DEPTH]
    assign cfg_ext = CW'(cfg_data);
    always_comb
    begin
        priority if (cfg_ext < CW'(RING_SIZE_MIN))
        begin
            size_next = SW'(RING_SIZE_MIN);
        end
        else if (cfg_ext > CW'(DEPTH))
        begin
            size_next = SW'(DEPTH);
        end
        else
        begin
            size_next = SW'(cfg_ext);
        end
    end

    // ring index arithmetic
    assign wr_inc = SW'(wr_idx_reg) + SW'(1);
    assign rd_inc = SW'(rd_idx_reg) + SW'(1);
    assign wr_adv = (wr_inc >= size_reg) ? '0 : IW'(wr_inc);
    assign rd_adv = (rd_inc >= size_reg) ? '0 : IW'(rd_inc);
    assign full   = (wr_adv == rd_idx_reg);
    assign avail  = (wr_idx_reg >= rd_idx_reg)
                  ? (SW'(wr_idx_reg) - SW'(rd_idx_reg))
                  : (SW'(wr_idx_reg) + size_reg - SW'(rd_idx_reg));

    // write burst bookkeeping
    assign refused  = first_of_burst ? full : burst_ref_reg;
    assign store    = !refused && !full;
    assign cnt_base = first_of_burst ? '0 : burst_cnt_reg;
    assign cnt_new  = (store && (cnt_base < COUNT_MAX)) ? (cnt_base + COUNT_W'(1)) : cnt_base;

    // read sizing
    assign len_clamp = (read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : read_length;
    assign avail_ext = MW'(avail);
    assign len_ext   = MW'(len_clamp);
    assign take      = (avail_ext < len_ext) ? LW'(avail_ext) : LW'(len_ext);

    assign dp_status.empty      = (wr_idx_reg == rd_idx_reg);
    assign dp_status.len_zero   = (read_length == '0);
    assign dp_status.final_byte = (remain_reg == LW'(1));
    assign dp_status.out_free   = !out_valid_reg || out_ready;

    assign out_load = (cmd.do_write && last_of_burst) || cmd.rd_block
                    || cmd.rd_zero || cmd.rd_emit;

    // slot memory, synchronous read
    always_ff @(posedge clk)
    begin
        if (cmd.do_write && store)
        begin
            slot_mem[wr_idx_reg] <= data_byte;
        end
        if (cmd.fetch)
        begin
            mem_q <= slot_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SW'(RESET_SIZE);
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            burst_cnt_reg <= '0;
            burst_ref_reg <= 1'b0;
            remain_reg    <= '0;
            rcount_reg    <= '0;
        end
        else if (cfg_write)
        begin
            // resize empties the ring
            size_reg      <= size_next;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            burst_cnt_reg <= '0;
            burst_ref_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_write)
            begin
                if (store)
                begin
                    wr_idx_reg <= wr_adv;
                end
                if (last_of_burst)
                begin
                    burst_cnt_reg <= '0;
                    burst_ref_reg <= 1'b0;
                end
                else
                begin
                    burst_cnt_reg <= cnt_new;
                    burst_ref_reg <= refused;
                end
            end
            if (cmd.fetch)
            begin
                rd_idx_reg <= rd_adv;
            end
            if (cmd.rd_start)
            begin
                remain_reg <= take;
                rcount_reg <= '0;
            end
            else if (cmd.rd_emit)
            begin
                remain_reg <= remain_reg - LW'(1);
                rcount_reg <= rcount_reg + LW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            priority if (cmd.rd_emit)
            begin
                status_reg     <= ST_READ_BYTE;
                read_byte_reg  <= mem_q;
                byte_count_reg <= COUNT_W'(rcount_reg) + COUNT_W'(1);
                last_reg       <= dp_status.final_byte;
            end
            else if (cmd.rd_block)
            begin
                status_reg     <= ST_READ_BLOCK;
                read_byte_reg  <= '0;
                byte_count_reg <= '0;
                last_reg       <= 1'b1;
            end
            else if (cmd.rd_zero)
            begin
                status_reg     <= ST_READ_EMPTY;
                read_byte_reg  <= '0;
                byte_count_reg <= '0;
                last_reg       <= 1'b1;
            end
            else
            begin
                status_reg     <= refused ? ST_WRITE_BLOCK : ST_WRITE_DONE;
                read_byte_reg  <= '0;
                byte_count_reg <= refused ? '0 : cnt_new;
                last_reg       <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_byte   = read_byte_reg;
    assign byte_count  = byte_count_reg;
    assign last_result = last_reg;

endmodule : rbbt_datapath
`default_nettype wire

[hw/rtl/ring_buffer_bulk_transfer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_bulk_transfer_core
// Byte ring buffer with run-time size and one slot kept free, taking write
// bursts one byte per beat and serving length-limited read requests.
// ----------------------------------------------------------------------------
// Write bursts stream at one byte per cycle while the output register is
// free or being drained; only the last beat of a burst produces a result.
// Once a read request is accepted, its N bytes leave at one per cycle as
// long as the sink takes them; the slot memory's single registered read
// port sets this pace, each byte being fetched while the one before it sits
// in the output register. Would-block and empty-read answers go straight
// into the output register. A new beat is accepted once the final byte of a
// read is loaded and the output register is free or being drained. Writing
// ring_size empties the ring; write it only while the block is idle. The
// slot memory is not cleared and needs no setup time after reset.
// ----------------------------------------------------------------------------
module ring_buffer_bulk_transfer_core
#(
    parameter int DEPTH    = rbbt_pkg::DEPTH_DEFAULT,
    parameter int MAX_READ = rbbt_pkg::MAX_READ_DEFAULT
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write,
    input  wire  [rbbt_pkg::SIZE_CFG_W-1:0]    cfg_data,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                operation,
    input  wire  [7:0]                         data_byte,
    input  wire                                first_of_burst,
    input  wire                                last_of_burst,
    input  wire  [rbbt_pkg::LEN_W-1:0]         read_length,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [rbbt_pkg::STATUS_W-1:0]      status,
    output logic [7:0]                         read_byte,
    output logic [rbbt_pkg::COUNT_W-1:0]       byte_count,
    output logic                               last_result
);
    import rbbt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    rbbt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .dp_status (dp_status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    rbbt_datapath
    #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .data_byte      (data_byte),
        .first_of_burst (first_of_burst),
        .last_of_burst  (last_of_burst),
        .read_length    (read_length),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .read_byte      (read_byte),
        .byte_count     (byte_count),
        .last_result    (last_result)
    );

    // a beat is only taken when its result has somewhere to go
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!out_valid || out_ready))
        else $error("beat accepted while output register is blocked");

    // a read that moves bytes holds off input until its bytes are out
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_start |=> !in_ready)
        else $error("input ready right after a read started");

    // only read bytes come without the final mark
    a_nonlast_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |-> (status == ST_READ_BYTE))
        else $error("non-final result that is not a read byte");

endmodule : ring_buffer_bulk_transfer_core
`default_nettype wire
